// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define RDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/rdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

    localparam int PROCESSES_DEF  = 8;
    localparam int RESOURCES_DEF  = 4;
    localparam int COUNT_BITS_DEF = 8;

    localparam int ACTION_W = 2;
    localparam int PROC_W   = 3;
    localparam int RES_W    = 2;
    localparam int FIELD_W  = 8;
    localparam int MASK_W   = 8;

    localparam logic [ACTION_W-1:0] ACT_ENTRY = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd2;

    typedef struct packed {
        logic init;
        logic step;
        logic load_out;
    } rdd_cmd_t;

    typedef struct packed {
        logic last;
        logic more;
        logic out_free;
    } rdd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/resource_deadlock_detector.sv =====
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: action; tdata: process, resource, held, wanted, free_count
// m_axis    out  tdata: deadlock, stuck_mask
//
// Load transactions are accepted back to back while no check is in progress.
// A check scans the processes in passes; passes is 1 to PROCESSES + 1, with
// the scan counter walking one process per cycle through the shared compare/add unit.
// Input is stalled from a check's acceptance until its result enters the output register.
// A full output register holds the next check in its final state, with input still stalled.
// Reset clears all count stores, the finished flags and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module resource_deadlock_detector #(
    parameter int PROCESSES  = rdd_pkg::PROCESSES_DEF,
    parameter int RESOURCES  = rdd_pkg::RESOURCES_DEF,
    parameter int COUNT_BITS = rdd_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // process, resource, held, wanted, free_count
    input  wire logic [1:0]  s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata   // deadlock, stuck_mask
);
    import rdd_pkg::*;

    localparam int PW        = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int WORK_BITS = COUNT_BITS + $clog2(PROCESSES + 1);

    logic [ACTION_W-1:0] action;
    logic [PROC_W-1:0]   process;
    logic [RES_W-1:0]    resource;
    logic [FIELD_W-1:0]  held;
    logic [FIELD_W-1:0]  wanted;
    logic [FIELD_W-1:0]  free_count;
    logic                in_fire;

    logic [COUNT_BITS-1:0] held_row   [RESOURCES];
    logic [COUNT_BITS-1:0] wanted_row [RESOURCES];
    logic [COUNT_BITS-1:0] free_row   [RESOURCES];
    logic [PW-1:0]         rd_ptr;

    rdd_cmd_t          cmd;
    rdd_stat_t         stat;
    logic              deadlock;
    logic [MASK_W-1:0] stuck_mask;

    assign action     = s_axis_tuser;
    assign process    = s_axis_tdata[2:0];
    assign resource   = s_axis_tdata[4:3];
    assign held       = s_axis_tdata[12:5];
    assign wanted     = s_axis_tdata[20:13];
    assign free_count = s_axis_tdata[28:21];
    assign in_fire    = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata = {7'd0, stuck_mask, deadlock};

    rdd_store #(
        .PROCESSES  (PROCESSES),
        .RESOURCES  (RESOURCES),
        .COUNT_BITS (COUNT_BITS),
        .PW         (PW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_fire),
        .action     (action),
        .process    (process),
        .resource   (resource),
        .held       (held),
        .wanted     (wanted),
        .free_count (free_count),
        .rd_ptr     (rd_ptr),
        .held_row   (held_row),
        .wanted_row (wanted_row),
        .free_row   (free_row)
    );

    rdd_datapath #(
        .PROCESSES  (PROCESSES),
        .RESOURCES  (RESOURCES),
        .COUNT_BITS (COUNT_BITS),
        .PW         (PW),
        .WORK_BITS  (WORK_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .held_row   (held_row),
        .wanted_row (wanted_row),
        .free_row   (free_row),
        .rd_ptr     (rd_ptr),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .deadlock   (deadlock),
        .stuck_mask (stuck_mask)
    );

    rdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_check (action == ACT_CHECK),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    `RDD_ASSERT_NEXT(a_busy_after_check, clk, rst_n, in_fire && (action == ACT_CHECK),
        !s_axis_tready, "input not stalled after check")
    `RDD_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.load_out, stat.out_free,
        "pending result overwritten")
    `RDD_ASSERT_SAME(a_mask_implies_dead, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[8:1] != 8'd0), m_axis_tdata[0],
        "stuck process without deadlock")

endmodule

`default_nettype wire

// ===== rtl/rdd_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdd_store #(
    parameter int PROCESSES  = 8,
    parameter int RESOURCES  = 4,
    parameter int COUNT_BITS = 8,
    parameter int PW         = 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [rdd_pkg::ACTION_W-1:0] action,
    input  wire logic [rdd_pkg::PROC_W-1:0]   process,
    input  wire logic [rdd_pkg::RES_W-1:0]    resource,
    input  wire logic [rdd_pkg::FIELD_W-1:0]  held,
    input  wire logic [rdd_pkg::FIELD_W-1:0]  wanted,
    input  wire logic [rdd_pkg::FIELD_W-1:0]  free_count,
    input  wire logic [PW-1:0]                rd_ptr,
    output logic      [COUNT_BITS-1:0]        held_row   [RESOURCES],
    output logic      [COUNT_BITS-1:0]        wanted_row [RESOURCES],
    output logic      [COUNT_BITS-1:0]        free_row   [RESOURCES]
);
    import rdd_pkg::*;

    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    logic [COUNT_BITS-1:0] held_reg   [PROCESSES][RESOURCES];
    logic [COUNT_BITS-1:0] wanted_reg [PROCESSES][RESOURCES];
    logic [COUNT_BITS-1:0] free_reg   [RESOURCES];

    logic proc_ok;
    logic res_ok;
    logic entry_we;
    logic free_we;

    assign proc_ok  = 32'(process) < PROCESSES;
    assign res_ok   = 32'(resource) < RESOURCES;
    assign entry_we = wr_en && (action == ACT_ENTRY) && proc_ok && res_ok;
    assign free_we  = wr_en && (action == ACT_FREE) && res_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PROCESSES; p++)
            begin
                for (int r = 0; r < RESOURCES; r++)
                begin
                    held_reg[p][r]   <= '0;
                    wanted_reg[p][r] <= '0;
                end
            end
            for (int r = 0; r < RESOURCES; r++)
            begin
                free_reg[r] <= '0;
            end
        end
        else
        begin
            if (entry_we)
            begin
                held_reg[PW'(process)][RW'(resource)]   <= COUNT_BITS'(held);
                wanted_reg[PW'(process)][RW'(resource)] <= COUNT_BITS'(wanted);
            end
            if (free_we)
            begin
                free_reg[RW'(resource)] <= COUNT_BITS'(free_count);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            held_row[r]   = held_reg[rd_ptr][r];
            wanted_row[r] = wanted_reg[rd_ptr][r];
            free_row[r]   = free_reg[r];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rdd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdd_datapath #(
    parameter int PROCESSES  = 8,
    parameter int RESOURCES  = 4,
    parameter int COUNT_BITS = 8,
    parameter int PW         = 3,
    parameter int WORK_BITS  = 12
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rdd_pkg::rdd_cmd_t           cmd,
    output rdd_pkg::rdd_stat_t               stat,
    input  wire logic [COUNT_BITS-1:0]       held_row   [RESOURCES],
    input  wire logic [COUNT_BITS-1:0]       wanted_row [RESOURCES],
    input  wire logic [COUNT_BITS-1:0]       free_row   [RESOURCES],
    output logic      [PW-1:0]               rd_ptr,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             deadlock,
    output logic      [rdd_pkg::MASK_W-1:0]  stuck_mask
);
    import rdd_pkg::*;

    logic [WORK_BITS-1:0] work_reg [RESOURCES];
    logic [PROCESSES-1:0] finished_reg;
    logic [PW-1:0]        ptr_reg;
    logic                 progress_reg;
    logic                 out_valid_reg;
    logic                 deadlock_reg;
    logic [MASK_W-1:0]    mask_reg;

    logic                 fits;
    logic                 fire;
    logic                 last;
    logic [PROCESSES-1:0] unfinished;

    always_comb
    begin
        fits = 1'b1;
        for (int r = 0; r < RESOURCES; r++)
        begin
            if (WORK_BITS'(wanted_row[r]) > work_reg[r])
            begin
                fits = 1'b0;
            end
        end
    end

    assign fire       = !finished_reg[ptr_reg] && fits;
    assign last       = ptr_reg == PW'(PROCESSES - 1);
    assign unfinished = ~finished_reg;

    assign stat.last     = last;
    assign stat.more     = progress_reg || fire;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign rd_ptr     = ptr_reg;
    assign out_valid  = out_valid_reg;
    assign deadlock   = deadlock_reg;
    assign stuck_mask = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg  <= '0;
            ptr_reg       <= '0;
            progress_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init)
            begin
                finished_reg <= '0;
                ptr_reg      <= '0;
                progress_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (fire)
                begin
                    finished_reg[ptr_reg] <= 1'b1;
                end
                if (last)
                begin
                    ptr_reg      <= '0;
                    progress_reg <= 1'b0;
                end
                else
                begin
                    ptr_reg      <= ptr_reg + PW'(1);
                    progress_reg <= progress_reg || fire;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            if (cmd.init)
            begin
                work_reg[r] <= WORK_BITS'(free_row[r]);
            end
            else if (cmd.step && fire)
            begin
                work_reg[r] <= work_reg[r] + WORK_BITS'(held_row[r]);
            end
        end
        if (cmd.load_out)
        begin
            deadlock_reg <= |unfinished;
            mask_reg     <= MASK_W'(unfinished);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rdd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_check,
    output logic                    in_ready,
    input  wire rdd_pkg::rdd_stat_t stat,
    output rdd_pkg::rdd_cmd_t       cmd
);
    import rdd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready     = state_reg == ST_IDLE;
    assign cmd.init     = in_ready && in_valid && in_check;
    assign cmd.step     = state_reg == ST_SCAN;
    assign cmd.load_out = (state_reg == ST_DONE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.init)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.last && !stat.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rdd_pkg::*;

    localparam int NUM_PROCS    = PROCESSES_DEF;
    localparam int NUM_RES      = RESOURCES_DEF;
    localparam int DRAIN_CYCLES = 1 + (NUM_PROCS + 1) * NUM_PROCS + 1 + 20;
    localparam int LIMIT_CYCLES = 600000;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic              deadlock;
        logic [MASK_W-1:0] stuck_mask;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // process, resource, held, wanted, free_count
    logic [1:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // deadlock, stuck_mask

    logic [FIELD_W-1:0] held_tab   [NUM_PROCS][NUM_RES];
    logic [FIELD_W-1:0] wanted_tab [NUM_PROCS][NUM_RES];
    logic [FIELD_W-1:0] free_tab   [NUM_RES];

    verdict_t pending_verdicts[$];
    int       mismatch_count;
    int       items_accepted;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       cycle_count;

    resource_deadlock_detector DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic verdict_t evaluate_deadlock();
        logic [10:0]          work [NUM_RES];
        logic [NUM_PROCS-1:0] done;
        logic                 progress;
        logic                 fits;
        verdict_t             v;
        for (int r = 0; r < NUM_RES; r++)
            work[r] = {3'b000, free_tab[r]};
        done     = '0;
        progress = 1'b1;
        while (progress)
        begin
            progress = 1'b0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                if (!done[p])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < NUM_RES; r++)
                        if ({3'b000, wanted_tab[p][r]} > work[r])
                            fits = 1'b0;
                    if (fits)
                    begin
                        for (int r = 0; r < NUM_RES; r++)
                            work[r] = work[r] + {3'b000, held_tab[p][r]};
                        done[p]  = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        v.stuck_mask = ~done;
        v.deadlock   = |(~done);
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_count(input int scale);
        case (scale)
            0:       return FIELD_W'($urandom_range(0, 3));
            1:       return FIELD_W'($urandom_range(0, 40));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic [PROC_W-1:0]   proc,
                                input logic [RES_W-1:0]    res,
                                input logic [FIELD_W-1:0]  held,
                                input logic [FIELD_W-1:0]  wanted,
                                input logic [FIELD_W-1:0]  freec);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = action;
        s_axis_tdata  = {3'b000, freec, wanted, held, res, proc};
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (action)
            ACT_ENTRY:
            begin
                held_tab[proc][res]   = held;
                wanted_tab[proc][res] = wanted;
            end
            ACT_FREE:  free_tab[res] = freec;
            ACT_CHECK: pending_verdicts.push_back(evaluate_deadlock());
            default:   ;
        endcase
        if (action != ACT_UNUSED)
            items_accepted++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.deadlock)
                begin
                    $error("deadlock: expected %b, got %b", want.deadlock, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[8:1] !== want.stuck_mask)
                begin
                    $error("stuck_mask: expected %h, got %h", want.stuck_mask,
                           m_axis_tdata[8:1]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_ENTRY, 3'd0, 2'd0, 8'd255, 8'd0, 8'd255);
        send_request(ACT_ENTRY, 3'd0, 2'd3, 8'd0, 8'd255, 8'd0);
        send_request(ACT_CHECK, 3'd7, 2'd3, 8'd255, 8'd255, 8'd255);
        send_request(ACT_FREE, 3'd7, 2'd3, 8'd0, 8'd0, 8'd255);
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_FREE, 3'd0, 2'd3, 8'd255, 8'd255, 8'd0);
        send_request(ACT_ENTRY, 3'd0, 2'd3, 8'd0, 8'd0, 8'd0);
        send_request(ACT_ENTRY, 3'd1, 2'd1, 8'd0, 8'd1, 8'd0);
        send_request(ACT_ENTRY, 3'd1, 2'd2, 8'd1, 8'd0, 8'd0);
        send_request(ACT_ENTRY, 3'd2, 2'd2, 8'd0, 8'd1, 8'd0);
        send_request(ACT_ENTRY, 3'd2, 2'd1, 8'd1, 8'd0, 8'd0);
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_UNUSED, 3'd7, 2'd3, 8'd255, 8'd255, 8'd255);
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_ENTRY, 3'd7, 2'd1, 8'd1, 8'd0, 8'd0);
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        for (int r = 0; r < NUM_RES; r++)
            send_request(ACT_FREE, 3'd0, RES_W'(r), 8'd0, 8'd0, 8'd0);
        send_request(ACT_ENTRY, 3'd7, 2'd0, 8'd0, 8'd255, 8'd0);
        send_request(ACT_CHECK, 3'd0, 2'd0, 8'd0, 8'd0, 8'd0);
        hold_until_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int items);
        int goal;
        int scale;
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal           = items_accepted + items;
        while (items_accepted < goal)
        begin
            scale = $urandom_range(0, 2);
            n     = $urandom_range(0, 4);
            repeat (n)
                send_request(ACT_FREE, PROC_W'($urandom), RES_W'($urandom),
                             FIELD_W'($urandom), FIELD_W'($urandom), pick_count(scale));
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(ACTION_W'($urandom), PROC_W'($urandom), RES_W'($urandom),
                                 FIELD_W'($urandom), FIELD_W'($urandom),
                                 FIELD_W'($urandom));
                send_request(ACT_ENTRY, PROC_W'($urandom), RES_W'($urandom),
                             pick_count(scale), pick_count(scale), FIELD_W'($urandom));
            end
            send_request(ACT_CHECK, PROC_W'($urandom), RES_W'($urandom),
                         FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                send_request(ACT_CHECK, PROC_W'($urandom), RES_W'($urandom),
                             FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        items_accepted = 0;
        for (int p = 0; p < NUM_PROCS; p++)
            for (int r = 0; r < NUM_RES; r++)
            begin
                held_tab[p][r]   = '0;
                wanted_tab[p][r] = '0;
            end
        for (int r = 0; r < NUM_RES; r++)
            free_tab[r] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic(0, 0, 210);
        test_random_traffic(64, 0, 210);
        test_random_traffic(0, 64, 210);
        test_random_traffic(16, 16, 210);
        hold_until_drained();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
